FILE: hdl/srp_pkg.sv
// srp_pkg: shared types and constants for the star rotate and project block
// no dependencies; imported by every module of the block

package srp_pkg;

  localparam int ANGLE_W    = 16;  // q2.14 cosine and sine
  localparam int CENTER_W   = 12;  // screen centre registers
  localparam int DEPTH_W    = 8;   // depth, speed and shade
  localparam int INDEX_W    = 8;   // star index field
  localparam int SCREEN_W   = 16;  // saturated screen coordinates
  localparam int DIST_W     = 9;   // distance 1..256
  localparam int FRAC_SHIFT = 6;   // 16384 / 256 taken as a shift of the dividend
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [DIST_W-1:0] LENS_DEPTH = 9'd256;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_COS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd3;

  // word kinds
  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load_we;    // write a loaded star into the table
    logic fetch;      // read the addressed star entry
    logic mul;        // new depth, write back, rotation products
    logic sum;        // rotated sums, magnitudes and signs
    logic div_start;  // load both dividers
    logic out_load;   // fill the output register
  } srp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_range;   // star index below the table size
    logic is_advance; // input word is an advance
    logic div_done;   // quotients ready
    logic out_full;   // output register holds a word that is not taken
  } srp_stat_t;

endpackage

FILE: hdl/srp_if.sv
// srp_if: valid/ready channel interfaces for star words and projected results
// depends on srp_pkg for field widths

interface srp_in_if import srp_pkg::*; #(
  parameter int COORD_BITS = 12
);
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [INDEX_W-1:0]           star_index;
  logic signed [COORD_BITS-1:0] x_pos;
  logic signed [COORD_BITS-1:0] y_pos;
  logic [DEPTH_W-1:0]           depth;
  logic [DEPTH_W-1:0]           speed;

  modport source (output valid, kind, star_index, x_pos, y_pos, depth, speed,
                  input ready);
  modport sink   (input valid, kind, star_index, x_pos, y_pos, depth, speed,
                  output ready);
endinterface

interface srp_out_if import srp_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic [INDEX_W-1:0]         out_index;
  logic signed [SCREEN_W-1:0] screen_x;
  logic signed [SCREEN_W-1:0] screen_y;
  logic [DEPTH_W-1:0]         shade;
  logic                       clamped;

  modport source (output valid, out_index, screen_x, screen_y, shade, clamped,
                  input ready);
  modport sink   (input valid, out_index, screen_x, screen_y, shade, clamped,
                  output ready);
endinterface

FILE: hdl/srp_div.sv
// srp_div: radix-2 restoring divider, one quotient bit per cycle
// depends on srp_pkg for the divisor width

module srp_div import srp_pkg::*; #(
  parameter int NUM_W = 23
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [DIST_W-1:0] den,
  output logic [NUM_W-1:0]  quot,
  output logic              done
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0]  cnt;
  logic [NUM_W-1:0]  q;
  logic [DIST_W-1:0] rem;
  logic [DIST_W-1:0] den_reg;
  logic [DIST_W:0]   trial;
  logic              ge;
  logic [DIST_W-1:0] rem_next;

  always_comb begin
    trial    = {rem, q[NUM_W-1]};
    ge       = (trial >= {1'b0, den_reg});
    rem_next = ge ? DIST_W'(trial - {1'b0, den_reg}) : trial[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(NUM_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q       <= num;
      rem     <= '0;
      den_reg <= den;
    end else if (cnt != '0) begin
      q   <= {q[NUM_W-2:0], ge};
      rem <= rem_next;
    end
  end

  assign quot = q;
  assign done = (cnt == '0);

endmodule

FILE: hdl/srp_datapath.sv
// srp_datapath: configuration registers, star table, rotation, dividers and
// output register; depends on srp_pkg, srp_if and srp_div

module srp_datapath import srp_pkg::*; #(
  parameter int STAR_COUNT = 256,
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         kind,
  input  logic [INDEX_W-1:0]           star_index,
  input  logic signed [COORD_BITS-1:0] x_pos,
  input  logic signed [COORD_BITS-1:0] y_pos,
  input  logic [DEPTH_W-1:0]           depth,
  input  logic [DEPTH_W-1:0]           speed,
  input  srp_cmd_t                     cmd,
  output srp_stat_t                    stat,
  srp_out_if.source                    results_out
);

  localparam int IDX_W  = (STAR_COUNT > 1) ? $clog2(STAR_COUNT) : 1;
  localparam int WORD_W = 2 * COORD_BITS + 2 * DEPTH_W;
  localparam int PROD_W = COORD_BITS + ANGLE_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int NUM_W  = SUM_W - FRAC_SHIFT;
  localparam int SAT_W  = NUM_W + 2;

  localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(32767);
  localparam logic signed [SAT_W-1:0] SAT_MIN = SAT_W'(-32768);

  // configuration
  logic signed [ANGLE_W-1:0] cos_angle;
  logic signed [ANGLE_W-1:0] sin_angle;
  logic [CENTER_W-1:0]       center_x;
  logic [CENTER_W-1:0]       center_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_angle <= 16'sd16384;
      sin_angle <= '0;
      center_x  <= 12'd400;
      center_y  <= 12'd300;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COS:      cos_angle <= cfg_data;
        CFG_SIN:      sin_angle <= cfg_data;
        CFG_CENTER_X: center_x  <= cfg_data[CENTER_W-1:0];
        CFG_CENTER_Y: center_y  <= cfg_data[CENTER_W-1:0];
        default: ;
      endcase
    end
  end

  assign stat.in_range   = ({24'd0, star_index} < 32'(STAR_COUNT));
  assign stat.is_advance = (kind == KIND_ADVANCE);

  // star table: {x, y, depth, speed}
  logic [WORD_W-1:0] star_mem [STAR_COUNT];
  logic [WORD_W-1:0] rd_word;
  logic [WORD_W-1:0] wr_word;
  logic [IDX_W-1:0]  wr_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  in_addr;
  logic [INDEX_W-1:0] idx_reg;

  logic signed [COORD_BITS-1:0] rd_x;
  logic signed [COORD_BITS-1:0] rd_y;
  logic [DEPTH_W-1:0]           rd_depth;
  logic [DEPTH_W-1:0]           rd_speed;
  logic [DEPTH_W:0]             depth_sum;
  logic [DEPTH_W-1:0]           depth_wrap;

  assign in_addr  = IDX_W'(star_index);
  assign rd_x     = rd_word[WORD_W-1 -: COORD_BITS];
  assign rd_y     = rd_word[WORD_W-COORD_BITS-1 -: COORD_BITS];
  assign rd_depth = rd_word[2*DEPTH_W-1 -: DEPTH_W];
  assign rd_speed = rd_word[DEPTH_W-1:0];

  // wrap at the lens plane so the distance never reaches zero
  assign depth_sum  = {1'b0, rd_depth} + {1'b0, rd_speed};
  assign depth_wrap = depth_sum[DEPTH_W] ? '0 : depth_sum[DEPTH_W-1:0];

  always_comb begin
    wr_en = cmd.load_we | cmd.mul;
    if (cmd.mul) begin
      wr_addr = IDX_W'(idx_reg);
      wr_word = {rd_x, rd_y, depth_wrap, rd_speed};
    end else begin
      wr_addr = in_addr;
      wr_word = {x_pos, y_pos, depth, speed};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      star_mem[wr_addr] <= wr_word;
    end
    if (cmd.fetch) begin
      rd_word <= star_mem[in_addr];
      idx_reg <= star_index;
    end
  end

  // rotation products
  logic [DEPTH_W-1:0]       depth_new;
  logic signed [PROD_W-1:0] p_xc;
  logic signed [PROD_W-1:0] p_ys;
  logic signed [PROD_W-1:0] p_yc;
  logic signed [PROD_W-1:0] p_xs;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      depth_new <= depth_wrap;
      p_xc      <= rd_x * cos_angle;
      p_ys      <= rd_y * sin_angle;
      p_yc      <= rd_y * cos_angle;
      p_xs      <= rd_x * sin_angle;
    end
  end

  // rotated sums as sign and magnitude, the divide by 64 taken as a shift
  logic signed [SUM_W-1:0] rot_x;
  logic signed [SUM_W-1:0] rot_y;
  logic [SUM_W-1:0]        abs_x;
  logic [SUM_W-1:0]        abs_y;
  logic [NUM_W-1:0]        mag_x;
  logic [NUM_W-1:0]        mag_y;
  logic                    neg_x;
  logic                    neg_y;

  always_comb begin
    rot_x = SUM_W'(p_xc) - SUM_W'(p_ys);
    rot_y = SUM_W'(p_yc) + SUM_W'(p_xs);
    abs_x = rot_x[SUM_W-1] ? SUM_W'(-rot_x) : SUM_W'(rot_x);
    abs_y = rot_y[SUM_W-1] ? SUM_W'(-rot_y) : SUM_W'(rot_y);
  end

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      mag_x <= NUM_W'(abs_x >> FRAC_SHIFT);
      mag_y <= NUM_W'(abs_y >> FRAC_SHIFT);
      neg_x <= rot_x[SUM_W-1];
      neg_y <= rot_y[SUM_W-1];
    end
  end

  // two dividers by the distance, run side by side
  logic [DIST_W-1:0] lens_dist;
  logic [NUM_W-1:0]  quot_x;
  logic [NUM_W-1:0]  quot_y;
  logic              done_x;
  logic              done_y;

  assign lens_dist = LENS_DEPTH - {1'b0, depth_new};

  srp_div #(.NUM_W(NUM_W)) u_div_x (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (mag_x),
    .den   (lens_dist),
    .quot  (quot_x),
    .done  (done_x)
  );

  srp_div #(.NUM_W(NUM_W)) u_div_y (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (mag_y),
    .den   (lens_dist),
    .quot  (quot_y),
    .done  (done_y)
  );

  assign stat.div_done = done_x & done_y;

  // screen position and saturation
  logic signed [SAT_W-1:0]    q_x;
  logic signed [SAT_W-1:0]    q_y;
  logic signed [SAT_W-1:0]    full_x;
  logic signed [SAT_W-1:0]    full_y;
  logic signed [SCREEN_W-1:0] sat_x;
  logic signed [SCREEN_W-1:0] sat_y;
  logic                       clip_x;
  logic                       clip_y;

  always_comb begin
    q_x    = neg_x ? -$signed(SAT_W'(quot_x)) : $signed(SAT_W'(quot_x));
    q_y    = neg_y ? -$signed(SAT_W'(quot_y)) : $signed(SAT_W'(quot_y));
    full_x = $signed(SAT_W'(center_x)) + q_x;
    full_y = $signed(SAT_W'(center_y)) - q_y;
    clip_x = (full_x > SAT_MAX) || (full_x < SAT_MIN);
    clip_y = (full_y > SAT_MAX) || (full_y < SAT_MIN);
    if (full_x > SAT_MAX) begin
      sat_x = SAT_MAX[SCREEN_W-1:0];
    end else if (full_x < SAT_MIN) begin
      sat_x = SAT_MIN[SCREEN_W-1:0];
    end else begin
      sat_x = full_x[SCREEN_W-1:0];
    end
    if (full_y > SAT_MAX) begin
      sat_y = SAT_MAX[SCREEN_W-1:0];
    end else if (full_y < SAT_MIN) begin
      sat_y = SAT_MIN[SCREEN_W-1:0];
    end else begin
      sat_y = full_y[SCREEN_W-1:0];
    end
  end

  // output register
  logic out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (results_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      results_out.out_index <= idx_reg;
      results_out.screen_x  <= sat_x;
      results_out.screen_y  <= sat_y;
      results_out.shade     <= depth_new;
      results_out.clamped   <= clip_x | clip_y;
    end
  end

  assign results_out.valid = out_valid;
  assign stat.out_full     = out_valid & ~results_out.ready;

endmodule

FILE: hdl/srp_ctrl.sv
// srp_ctrl: sequencer for load and advance words
// depends on srp_pkg for the command and status structs

module srp_ctrl import srp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  srp_stat_t stat,
  output srp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_DIVGO,
    S_DIV,
    S_FIN
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  always_comb begin
    in_ready   = (state == S_IDLE);
    accept     = in_valid & in_ready;
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.load_we = accept & stat.in_range & ~stat.is_advance;
        cmd.fetch   = accept & stat.in_range & stat.is_advance;
        if (cmd.fetch) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_DIVGO;
      end
      S_DIVGO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!stat.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: hdl/star_rotate_project.sv
// star_rotate_project: top level of the star table with rotation and projection
// depends on srp_pkg, srp_if, srp_ctrl, srp_datapath and srp_div
//
// load word: written into the star table at the accepting edge
// advance word: steps through fetch, multiply, sum, divider start, divide and output
//   load, waiting for a free output register; no new word is taken until it is done,
//   with the two radix-2 dividers making one quotient bit per cycle over COORD_BITS+11 bits
// rst (synchronous) clears the sequencer, the output valid and the configuration
//   registers to cos 16384, sin 0, centre (400, 300); the star table is not cleared

module star_rotate_project import srp_pkg::*; #(
  parameter int STAR_COUNT = 256,
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  srp_in_if.sink                stars_in,
  srp_out_if.source             results_out
);

  // command and status between sequencer and datapath
  srp_cmd_t  cmd;
  srp_stat_t stat;

  // sequencer: takes words only when idle, steps the advance through
  // fetch, multiply, sum, divide and output
  srp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stars_in.valid),
    .in_ready (stars_in.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: table memory with a registered read, four rotation products,
  // sign and magnitude, twin dividers and the saturating output word register
  srp_datapath #(
    .STAR_COUNT (STAR_COUNT),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .kind        (stars_in.kind),
    .star_index  (stars_in.star_index),
    .x_pos       (stars_in.x_pos),
    .y_pos       (stars_in.y_pos),
    .depth       (stars_in.depth),
    .speed       (stars_in.speed),
    .cmd         (cmd),
    .stat        (stat),
    .results_out (results_out)
  );

endmodule

FILE: hdl/srp_checker.sv
// srp_port_checker: port level checks on the star rotate and project block
// depends on srp_pkg; bound to star_rotate_project below

module srp_port_checker import srp_pkg::*; #(
  parameter int STAR_COUNT = 256
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_kind,
  input logic [INDEX_W-1:0]         in_index,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [INDEX_W-1:0]         out_index,
  input logic signed [SCREEN_W-1:0] screen_x,
  input logic signed [SCREEN_W-1:0] screen_y,
  input logic [DEPTH_W-1:0]         shade,
  input logic                       clamped
);

  logic adv_accept;
  assign adv_accept = in_valid && in_ready && (in_kind == KIND_ADVANCE) &&
                      ({24'd0, in_index} < 32'(STAR_COUNT));

  // an advance keeps the input closed while it works through the divider
  a_busy_after_advance: assert property (@(posedge clk) disable iff (rst)
    adv_accept |=> !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("input reopened too early after an advance word");

  // a waiting result word holds still
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_index) &&
      $stable(screen_x) && $stable(screen_y) && $stable(shade) && $stable(clamped))
    else $error("result word changed while stalled");

  // a clamp always lands on a limit of the 16 bit range
  a_clamp_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && screen_x != 16'sh7fff && screen_x != 16'sh8000 &&
      screen_y != 16'sh7fff && screen_y != 16'sh8000 |-> !clamped)
    else $error("clamp flag set on an unsaturated position");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind star_rotate_project srp_port_checker #(.STAR_COUNT(STAR_COUNT)) u_srp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (stars_in.valid),
  .in_ready  (stars_in.ready),
  .in_kind   (stars_in.kind),
  .in_index  (stars_in.star_index),
  .out_valid (results_out.valid),
  .out_ready (results_out.ready),
  .out_index (results_out.out_index),
  .screen_x  (results_out.screen_x),
  .screen_y  (results_out.screen_y),
  .shade     (results_out.shade),
  .clamped   (results_out.clamped)
);
